FILE: hdl/ssc_pkg.sv
// Shared types, sizes and the address helper for the sized subset-sum counter.
// Used by every module of the block but ssc_ways_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ssc_pkg;

    localparam int MAX_COINS = 32;
    localparam int MAX_SUM   = 511;

    localparam int PICK_ROWS = MAX_COINS + 1;
    localparam int SUM_COLS  = MAX_SUM + 1;
    localparam int DEPTH     = PICK_ROWS * SUM_COLS;

    localparam int ROW_W  = $clog2(PICK_ROWS);
    localparam int COL_W  = $clog2(SUM_COLS);
    localparam int IDX_W  = (ROW_W > COL_W) ? ROW_W : COL_W;
    localparam int EXT_W  = IDX_W + 2;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam int COIN_W = 6;
    localparam int PICK_W = 6;
    localparam int TGT_W  = 9;
    localparam int CNT_W  = 30;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_count;

    // One table update on its way to write-back.
    typedef struct packed {
        logic  valid;
        t_addr waddr;
        logic  fresh;     // first touch of this row: old value counts as zero
        logic  lo_force;  // lower entry is known without a read
        logic  lo_one;    // known lower entry value (one or zero)
    } t_issue;

    typedef struct packed {
        t_addr a_addr;
        t_addr b_addr;
    } t_rd_req;

    function automatic t_addr ways_addr(input logic [ROW_W-1:0] row,
                                        input logic [COL_W-1:0] col);
        return t_addr'(row) * t_addr'(SUM_COLS) + t_addr'(col);
    endfunction

endpackage

`default_nettype wire

FILE: hdl/ssc_ways_ram.sv
// Scratch table of ways: one write port, two read ports with registered data.
// Generic; sized by the instantiating module from ssc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssc_ways_ram #(
    parameter int DEPTH  = 16896,
    parameter int ADDR_W = 15,
    parameter int DATA_W = 30
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr_a,
    input  wire logic [ADDR_W-1:0] i_raddr_b,
    output logic      [DATA_W-1:0] o_rdata_a,
    output logic      [DATA_W-1:0] o_rdata_b
);

    logic [DATA_W-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

FILE: hdl/ssc_accum_unit.sv
// Shared update adder: old entry plus the entry one pick smaller, 30-bit wrap.
// Depends on ssc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssc_accum_unit (
    input  wire ssc_pkg::t_count i_old,
    input  wire ssc_pkg::t_count i_lo,
    input  wire logic            i_fresh,
    input  wire logic            i_lo_force,
    input  wire logic            i_lo_one,
    output ssc_pkg::t_count      o_sum
);

    ssc_pkg::t_count old_term;
    ssc_pkg::t_count lo_term;

    always_comb begin
        old_term = i_fresh ? '0 : i_old;
        lo_term  = i_lo_force ? ssc_pkg::t_count'(i_lo_one) : i_lo;
        o_sum    = old_term + lo_term;
    end

endmodule

`default_nettype wire

FILE: hdl/ssc_sequencer.sv
// Item sequencer: walks values, picks and sums, issues table updates and the final read.
// Depends on ssc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssc_sequencer (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [ssc_pkg::COIN_W-1:0]   i_coin_count,
    input  wire logic [ssc_pkg::PICK_W-1:0]   i_pick_count,
    input  wire logic [ssc_pkg::TGT_W-1:0]    i_target_sum,
    input  wire ssc_pkg::t_count              i_rdata_a,
    input  wire logic                         i_res_take,
    output logic                              o_busy,
    output logic                              o_res_valid,
    output ssc_pkg::t_count                   o_result,
    output ssc_pkg::t_issue                   o_issue,
    output ssc_pkg::t_rd_req                  o_rd_req
);

    localparam int ROW_W = ssc_pkg::ROW_W;
    localparam int COL_W = ssc_pkg::COL_W;
    localparam int EXT_W = ssc_pkg::EXT_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PLAN   = 3'd1;
    localparam logic [2:0] S_VSTART = 3'd2;
    localparam logic [2:0] S_SWEEP  = 3'd3;
    localparam logic [2:0] S_FETCH  = 3'd4;
    localparam logic [2:0] S_WAIT   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]       r_state, n_state;
    logic [ROW_W-1:0] r_coins, n_coins;
    logic [ROW_W-1:0] r_picks, n_picks;
    logic [COL_W-1:0] r_target, n_target;
    logic             r_bad, n_bad;
    logic [ROW_W-1:0] r_v, n_v;
    logic [ROW_W-1:0] r_p, n_p;
    logic [COL_W-1:0] r_s, n_s;
    ssc_pkg::t_count  r_result, n_result;

    logic [EXT_W-1:0] v_x, p_x, s_x, tgt_x, picks_x, coins_x, diff_x;
    logic [ROW_W-1:0] lo_row;
    logic [COL_W-1:0] lo_col;

    always_comb begin
        v_x     = EXT_W'(r_v);
        p_x     = EXT_W'(r_p);
        s_x     = EXT_W'(r_s);
        tgt_x   = EXT_W'(r_target);
        picks_x = EXT_W'(r_picks);
        coins_x = EXT_W'(r_coins);
        diff_x  = s_x - v_x;
        lo_row  = r_p - ROW_W'(1);
        lo_col  = COL_W'(diff_x);
    end

    // Update for (p, s) at value v: old entry fresh on the row's first pass,
    // lower entry known for row zero and for sums below its reachable range.
    always_comb begin
        o_issue.valid    = (r_state == S_SWEEP);
        o_issue.waddr    = ssc_pkg::ways_addr(r_p, r_s);
        o_issue.fresh    = (p_x == v_x + EXT_W'(1));
        o_issue.lo_force = (r_p == ROW_W'(1)) || (diff_x + EXT_W'(2) < p_x);
        o_issue.lo_one   = (r_p == ROW_W'(1)) && (diff_x == '0);
        o_rd_req.a_addr  = (r_state == S_FETCH) ? ssc_pkg::ways_addr(r_picks, r_target)
                                                : ssc_pkg::ways_addr(r_p, r_s);
        o_rd_req.b_addr  = ssc_pkg::ways_addr(lo_row, lo_col);
    end

    always_comb begin
        n_state  = r_state;
        n_coins  = r_coins;
        n_picks  = r_picks;
        n_target = r_target;
        n_bad    = r_bad;
        n_v      = r_v;
        n_p      = r_p;
        n_s      = r_s;
        n_result = r_result;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (32'(i_coin_count) > ssc_pkg::MAX_COINS) begin
                        n_coins = ROW_W'(ssc_pkg::MAX_COINS);
                    end else begin
                        n_coins = ROW_W'(i_coin_count);
                    end
                    n_picks  = ROW_W'(i_pick_count);
                    n_target = COL_W'(i_target_sum);
                    n_bad    = (32'(i_pick_count) > ssc_pkg::MAX_COINS) ||
                               (32'(i_target_sum) > ssc_pkg::MAX_SUM);
                    n_state  = S_PLAN;
                end
            end
            S_PLAN: begin
                if (r_bad) begin
                    n_result = '0;
                    n_state  = S_DONE;
                end else if (r_picks == '0) begin
                    n_result = ssc_pkg::t_count'(r_target == '0);
                    n_state  = S_DONE;
                end else begin
                    n_v     = '0;
                    n_state = S_VSTART;
                end
            end
            S_VSTART: begin
                if ((v_x < coins_x) && (v_x <= tgt_x)) begin
                    n_p     = (v_x + EXT_W'(1) < picks_x) ? r_v + ROW_W'(1) : r_picks;
                    n_s     = r_target;
                    n_state = S_SWEEP;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_SWEEP: begin
                if (s_x == v_x) begin
                    if (r_p == ROW_W'(1)) begin
                        n_v     = r_v + ROW_W'(1);
                        n_state = S_VSTART;
                    end else begin
                        n_p = r_p - ROW_W'(1);
                        n_s = r_target;
                    end
                end else begin
                    n_s = r_s - COL_W'(1);
                end
            end
            S_FETCH: begin
                if ((coins_x < picks_x) || (tgt_x + EXT_W'(1) < picks_x)) begin
                    n_result = '0;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_result = i_rdata_a;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_coins  <= n_coins;
        r_picks  <= n_picks;
        r_target <= n_target;
        r_bad    <= n_bad;
        r_v      <= n_v;
        r_p      <= n_p;
        r_s      <= n_s;
        r_result <= n_result;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_result    = r_result;

endmodule

`default_nettype wire

FILE: hdl/sized_subset_sum_counter_top.sv
// Top level of the sized subset-sum counter: sequencer, shared adder, ways table, output register.
// Depends on ssc_pkg, ssc_ways_ram, ssc_accum_unit and ssc_sequencer.
//
// Usage
//   Input channel: i_in_valid / o_in_stall with i_coin_count, i_pick_count, i_target_sum.
//   A transfer happens at a rising edge with i_in_valid high and o_in_stall low.
//   Output channel: o_out_valid / i_out_stall with o_combinations, one result per item.
//   The block works on one item at a time; o_in_stall stays high from the transfer until
//   the result has moved into the output register.
//   Table updates: one per cycle through the shared adder, in all
//     sum over v of min(v+1, pick_count) * (target_sum - v + 1)
//   where v runs over 0 .. min(coin_count, MAX_COINS, target_sum + 1) - 1. The single
//   adder and the one write port of the ways table set this rate; items with zero
//   picks or an out-of-range pick_count or target_sum skip the sweep and go from S_PLAN to S_DONE.
//   The table is never swept clean: each row's first pass writes rather than adds, and
//   entries outside the reachable range read as zero, so no clearing time is spent.
//   Reset (synchronous, active low) returns the sequencer to idle and empties the output
//   register; the table contents are left as they are.
//   While the receiver stalls, hold the result in the output register; a further item
//   may be taken and worked out meanwhile, and its result waits in the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module sized_subset_sum_counter_top (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [ssc_pkg::COIN_W-1:0] i_coin_count,
    input  wire logic [ssc_pkg::PICK_W-1:0] i_pick_count,
    input  wire logic [ssc_pkg::TGT_W-1:0]  i_target_sum,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [ssc_pkg::CNT_W-1:0]       o_combinations
);

    logic              seq_busy;
    logic              res_valid;
    logic              res_take;
    logic              in_xfer;
    ssc_pkg::t_count   seq_result;
    ssc_pkg::t_issue   issue;
    ssc_pkg::t_rd_req  rd_req;
    ssc_pkg::t_count   rdata_a;
    ssc_pkg::t_count   rdata_b;
    ssc_pkg::t_count   upd_sum;

    // Write-back stage: the update issued last cycle, its read data now valid.
    ssc_pkg::t_issue   r_wb;

    logic              r_out_valid;
    ssc_pkg::t_count   r_out_comb;

    assign in_xfer    = i_in_valid && !o_in_stall;
    assign o_in_stall = seq_busy;

    // Move the finished result out when the output register is empty or draining.
    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    ssc_sequencer u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (in_xfer),
        .i_coin_count (i_coin_count),
        .i_pick_count (i_pick_count),
        .i_target_sum (i_target_sum),
        .i_rdata_a    (rdata_a),
        .i_res_take   (res_take),
        .o_busy       (seq_busy),
        .o_res_valid  (res_valid),
        .o_result     (seq_result),
        .o_issue      (issue),
        .o_rd_req     (rd_req)
    );

    ssc_ways_ram #(
        .DEPTH  (ssc_pkg::DEPTH),
        .ADDR_W (ssc_pkg::ADDR_W),
        .DATA_W (ssc_pkg::CNT_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (r_wb.valid),
        .i_waddr   (r_wb.waddr),
        .i_wdata   (upd_sum),
        .i_raddr_a (rd_req.a_addr),
        .i_raddr_b (rd_req.b_addr),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    ssc_accum_unit u_acc (
        .i_old      (rdata_a),
        .i_lo       (rdata_b),
        .i_fresh    (r_wb.fresh),
        .i_lo_force (r_wb.lo_force),
        .i_lo_one   (r_wb.lo_one),
        .o_sum      (upd_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_wb <= issue;
            if (res_take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (res_take) begin
            r_out_comb <= seq_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_combinations = r_out_comb;

    // No read issued during the sweep may hit the entry being written back in the same cycle.
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue.valid && r_wb.valid) |->
            (r_wb.waddr != rd_req.a_addr) && (r_wb.waddr != rd_req.b_addr))
        else $error("table read collides with pending write-back");

    // An idle sequencer leaves no update in flight.
    a_idle_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !r_wb.valid)
        else $error("write-back pending while idle");

    // A transfer in makes the block busy on the next cycle.
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_in_stall)
        else $error("block not busy after input transfer");

    // A moved result shows up on the output.
    a_take_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_take |=> (o_out_valid && (o_combinations == $past(seq_result))))
        else $error("result not presented after take");

endmodule

`default_nettype wire
